// ----- sv/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescape unit.
package jsu_pkg;

   // End-of-string status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_ESC   = 2'd1;
   localparam logic [1:0] ST_TOO_SMALL = 2'd2;

   // Result kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Work queue between front and back
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

   // One queued job: up to four decoded bytes, optionally followed by a status word
   typedef struct packed {
      logic [2:0]      nbytes;
      logic [3:0][7:0] bytes;
      logic            has_end;
      logic [1:0]      status;
   } jsu_job_type;

endpackage

// ----- sv/json_string_unescape_utf8_unit.sv -----
// Top level of the JSON string unescape unit: config register, front, queue and back.
//
// Usage:
//   req_*  stream in: one raw string-body byte per word. req_tuser flags a word
//          that carries no byte and only ends an empty string; req_tlast ends a string.
//   rsp_*  stream out: decoded bytes (rsp_tuser = 0) and, at each string end, one
//          status word (rsp_tuser = 1: 0 ok, 1 bad escape, 2 output too small).
//          rsp_tlast marks the last result caused by one input word.
//   csr_*  write channel for the output capacity register (always ready).
// Path: an accepted input word is written to the job queue, then to the result register.
// Throughput: one input word per cycle while each word yields at most one result;
//   the result register sends one word per cycle, so a \u escape expanding to
//   N bytes occupies the output for N words, N + 1 with a status word at a string end.
//   A four-entry job queue between parser and serializer absorbs those bursts.
// Stall: while rsp_tready is low the output word holds, the queue fills and
//   req_tready drops once the queue is full; nothing is lost.
// Reset: clears parser state, queue and output valid; capacity returns to 4096.
module json_string_unescape_utf8_unit
   import jsu_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] end_only
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data     // output_capacity
);

   logic [12:0] cap_ff;
   logic        q_full, q_empty;
   logic        take;
   logic        push, pop;
   jsu_job_type push_job, head_job;
   logic [7:0]  out_byte;
   logic [1:0]  out_status;

   // capacity register; the user must write it only while idle, the block does not enforce it
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset)          cap_ff <= 13'd4096;
      else if (csr_valid) cap_ff <= csr_data;
   end

   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   jsu_front #(
      .MAX_CAPACITY(MAX_CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .in_byte  (req_tdata),
      .end_only (req_tuser),
      .last     (req_tlast),
      .capacity (cap_ff),
      .push     (push),
      .job      (push_job)
   );

   jsu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_empty (q_empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_byte   (out_byte),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_status, out_byte};

endmodule

// ----- sv/jsu_front.sv -----
// Front end: escape parser, UTF-8 encoder and capacity check; emits at most one job per word.
module jsu_front
   import jsu_pkg::*;
#(
   parameter int unsigned MAX_CAPACITY = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,       // input word accepted this cycle
   input  logic [7:0]        in_byte,
   input  logic              end_only,
   input  logic              last,
   input  logic [12:0]       capacity,   // configured capacity
   output logic              push,
   output jsu_job_type       job
);

   localparam int unsigned CAP_W = $clog2(MAX_CAPACITY + 1);
   localparam int unsigned CMP_W = ((CAP_W > 13) ? CAP_W : 13) + 1;

   localparam logic [3:0] PH_NORMAL = 4'd0;
   localparam logic [3:0] PH_ESC    = 4'd1;
   localparam logic [3:0] PH_HEX1   = 4'd2;
   localparam logic [3:0] PH_HEX2   = 4'd3;
   localparam logic [3:0] PH_HEX3   = 4'd4;
   localparam logic [3:0] PH_HEX4   = 4'd5;
   localparam logic [3:0] PH_LBS    = 4'd6;
   localparam logic [3:0] PH_LU     = 4'd7;
   localparam logic [3:0] PH_LHEX1  = 4'd8;
   localparam logic [3:0] PH_LHEX2  = 4'd9;
   localparam logic [3:0] PH_LHEX3  = 4'd10;
   localparam logic [3:0] PH_LHEX4  = 4'd11;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [15:0] HI_SUR_LO = 16'hd800;
   localparam logic [15:0] HI_SUR_HI = 16'hdbff;
   localparam logic [15:0] LO_SUR_LO = 16'hdc00;
   localparam logic [15:0] LO_SUR_HI = 16'hdfff;
   localparam logic [20:0] CP_1B_MAX = 21'h7f;
   localparam logic [20:0] CP_2B_MAX = 21'h7ff;
   localparam logic [20:0] CP_3B_MAX = 21'hffff;

   // {valid, value}
   function automatic logic [4:0] hex_val(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
      else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
      else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
      return r;
   endfunction

   logic [3:0]       phase_ff, phase_in;
   logic [15:0]      acc_ff, acc_in;
   logic [9:0]       hs_ff, hs_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic             disc_ff, disc_in;
   logic [1:0]       pend_ff, pend_in;

   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] need_sum;
   logic [4:0]       hv;
   logic [15:0]      acc_sh;
   logic             want_byte, want_cp;
   logic [7:0]       byte_val;
   logic [20:0]      cp;
   logic [2:0]       cp_len, need;
   logic [3:0][7:0]  enc;

   assign cap_eff = (CMP_W'(capacity) > CMP_W'(MAX_CAPACITY)) ?
                    CMP_W'(MAX_CAPACITY) : CMP_W'(capacity);
   assign hv      = hex_val(in_byte);
   assign acc_sh  = {acc_ff[11:0], hv[3:0]};

   always_comb begin
      if (cp <= CP_1B_MAX)      cp_len = 3'd1;
      else if (cp <= CP_2B_MAX) cp_len = 3'd2;
      else if (cp <= CP_3B_MAX) cp_len = 3'd3;
      else                      cp_len = 3'd4;
   end

   always_comb begin
      enc = '0;
      if (want_byte) begin
         enc[0] = byte_val;
      end else begin
         unique case (cp_len)
            3'd1: enc[0] = cp[7:0];
            3'd2: begin
               enc[0] = {3'b110, cp[10:6]};
               enc[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
               enc[0] = {4'b1110, cp[15:12]};
               enc[1] = {2'b10, cp[11:6]};
               enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
               enc[0] = {5'b11110, cp[20:18]};
               enc[1] = {2'b10, cp[17:12]};
               enc[2] = {2'b10, cp[11:6]};
               enc[3] = {2'b10, cp[5:0]};
            end
         endcase
      end
   end

   assign need     = want_byte ? 3'd1 : cp_len;
   assign need_sum = CMP_W'(count_ff) + CMP_W'(need);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      hs_in     = hs_ff;
      count_in  = count_ff;
      disc_in   = disc_ff;
      pend_in   = pend_ff;
      want_byte = 1'b0;
      want_cp   = 1'b0;
      byte_val  = in_byte;
      cp        = {5'd0, acc_sh};
      job       = '0;

      if (!end_only && !disc_ff) begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in  = PH_NORMAL;
               want_byte = 1'b1;
               unique case (in_byte)
                  CH_QUOTE:  byte_val = 8'h22;
                  CH_BSLASH: byte_val = 8'h5c;
                  CH_SLASH:  byte_val = 8'h2f;
                  CH_B:      byte_val = 8'h08;
                  CH_F:      byte_val = 8'h0c;
                  CH_N:      byte_val = 8'h0a;
                  CH_R:      byte_val = 8'h0d;
                  CH_T:      byte_val = 8'h09;
                  CH_U: begin
                     want_byte = 1'b0;
                     phase_in  = PH_HEX1;
                     acc_in    = '0;
                  end
                  default: begin
                     want_byte = 1'b0;
                     disc_in   = 1'b1;
                     pend_in   = ST_BAD_ESC;
                  end
               endcase
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4,
            PH_LHEX1, PH_LHEX2, PH_LHEX3, PH_LHEX4: begin
               if (!hv[4]) begin
                  disc_in  = 1'b1;
                  pend_in  = ST_BAD_ESC;
                  phase_in = PH_NORMAL;
               end else begin
                  acc_in = acc_sh;
                  if (phase_ff == PH_HEX4) begin
                     if (acc_sh >= HI_SUR_LO && acc_sh <= HI_SUR_HI) begin
                        hs_in    = acc_sh[9:0];
                        phase_in = PH_LBS;
                     end else begin
                        phase_in = PH_NORMAL;
                        want_cp  = 1'b1;
                     end
                  end else if (phase_ff == PH_LHEX4) begin
                     phase_in = PH_NORMAL;
                     if (acc_sh < LO_SUR_LO || acc_sh > LO_SUR_HI) begin
                        disc_in = 1'b1;
                        pend_in = ST_BAD_ESC;
                     end else begin
                        // 0x10000 + (hs << 10) + low ten bits
                        cp      = {({1'b0, hs_ff} + 11'd64), acc_sh[9:0]};
                        want_cp = 1'b1;
                     end
                  end else begin
                     phase_in = phase_ff + 4'd1;
                  end
               end
            end
            PH_LBS: begin
               if (in_byte == CH_BSLASH) begin
                  phase_in = PH_LU;
               end else begin
                  disc_in  = 1'b1;
                  pend_in  = ST_BAD_ESC;
                  phase_in = PH_NORMAL;
               end
            end
            PH_LU: begin
               if (in_byte == CH_U) begin
                  phase_in = PH_LHEX1;
                  acc_in   = '0;
               end else begin
                  disc_in  = 1'b1;
                  pend_in  = ST_BAD_ESC;
                  phase_in = PH_NORMAL;
               end
            end
            default: begin
               // normal bytes, also any unused phase code
               phase_in = PH_NORMAL;
               if (in_byte == CH_BSLASH) phase_in = PH_ESC;
               else                      want_byte = 1'b1;
            end
         endcase

         if (want_byte || want_cp) begin
            if (need_sum >= cap_eff) begin
               disc_in  = 1'b1;
               pend_in  = ST_TOO_SMALL;
               phase_in = PH_NORMAL;
            end else begin
               job.nbytes = need;
               job.bytes  = enc;
               count_in   = need_sum[CAP_W-1:0];
            end
         end
      end

      if (last) begin
         job.has_end = 1'b1;
         if (disc_in)                    job.status = pend_in;
         else if (phase_in != PH_NORMAL) job.status = ST_BAD_ESC;
         else                            job.status = ST_OK;
         phase_in = PH_NORMAL;
         acc_in   = '0;
         hs_in    = '0;
         count_in = '0;
         disc_in  = 1'b0;
         pend_in  = ST_OK;
      end
   end

   assign push = take && ((job.nbytes != 3'd0) || job.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         acc_ff   <= '0;
         hs_ff    <= '0;
         count_ff <= '0;
         disc_ff  <= 1'b0;
         pend_ff  <= ST_OK;
      end else if (take) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
         count_ff <= count_in;
         disc_ff  <= disc_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- sv/jsu_fifo.sv -----
// Short job queue decoupling the parser from the result serializer.
module jsu_fifo
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  jsu_job_type push_job,
   input  logic        pop,
   output jsu_job_type head_job,
   output logic        empty,
   output logic        full
);

   jsu_job_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in;
   logic [Q_PTR_W-1:0]   rd_ff, rd_in;
   logic [Q_PTR_W:0]     fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = mem_ff[rd_ff];

   assign wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign fill_in = fill_ff + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue underflow");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (Q_PTR_W + 1)'(Q_DEPTH)) else $error("queue fill out of range");

endmodule

// ----- sv/jsu_back.sv -----
// Back end: serializes queued jobs into result words through an output register.
module jsu_back
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  jsu_job_type head_job,
   input  logic        head_empty,
   output logic        pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_kind,
   output logic [7:0]  out_byte,
   output logic [1:0]  out_status,
   output logic        out_last
);

   logic [2:0] sel_ff, sel_in;
   logic [2:0] total;
   logic       is_last;
   logic       load;
   logic       valid_ff, valid_in;
   logic       kind_ff;
   logic [7:0] byte_ff;
   logic [1:0] status_ff;
   logic       last_ff;

   assign total   = head_job.nbytes + 3'(head_job.has_end);
   assign is_last = (sel_ff + 3'd1) == total;
   assign load    = !head_empty && (!valid_ff || out_ready);
   assign pop     = load && is_last;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = is_last ? 3'd0 : sel_ff + 3'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         last_ff <= is_last;
         if (sel_ff < head_job.nbytes) begin
            kind_ff   <= KIND_DATA;
            byte_ff   <= head_job.bytes[sel_ff[1:0]];
            status_ff <= ST_OK;
         end else begin
            kind_ff   <= KIND_END;
            byte_ff   <= 8'd0;
            status_ff <= head_job.status;
         end
      end
   end

   assign out_valid  = valid_ff;
   assign out_kind   = kind_ff;
   assign out_byte   = byte_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_END |-> last_ff) else $error("status word not last");
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_DATA |-> status_ff == ST_OK)
      else $error("data word with nonzero status");
   a_sel_in_job: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> sel_ff < total) else $error("serializer index past job");

endmodule
